>>> src/trn_pkg.sv
package trn_pkg;

  localparam int RING_DEPTH = 256;
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int CAPTURE_DEPTH = 64;
  localparam int CAP_AW = $clog2(CAPTURE_DEPTH);

  localparam logic [7:0] B_IAC = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB = 8'd250;
  localparam logic [7:0] B_SE = 8'd240;
  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_NAWS = 8'd31;
  localparam logic [7:0] SUB_SEND = 8'd1;
  localparam logic [7:0] SUB_IS = 8'd0;

  typedef enum logic [1:0] {
    ACT_RX = 2'd0,
    ACT_POP = 2'd1,
    ACT_NAME = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_REPLY = 3'd1,
    K_DATA = 3'd2,
    K_EMPTY = 3'd3,
    K_NAME = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PS_DATA, PS_CMD, PS_DONT, PS_SB, PS_WILL, PS_WONT, PS_DO, PS_SBOPT, PS_VAL, PS_VALIAC
  } pstate_t;

  typedef enum logic [1:0] {
    FS_RUN, FS_NAME, FS_EMIT
  } fstate_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_in;
    logic [5:0] name_index;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic last;
    logic echo_on;
    logic [15:0] window_cols;
    logic [15:0] window_rows;
    logic [8:0] data_count;
    logic [5:0] name_length;
  } out_t;

endpackage

>>> src/telnet_receive_negotiator_unit.sv
// channel | ports                          | word
// input   | in_valid in_ready in_data      | action, byte_in, name_index
// output  | out_valid out_ready out_data   | kind, value, last, status
// one word per cycle for plain bytes and commands without reply unless stalled
// replies are up to 9 bytes, one per word; pop and name read set a pending flag
// terminal name update at IAC SE copies one captured byte a cycle
// reset (rst_n low, synchronous) empties the ring and clears all status
// a stalled output holds its word; input waits until that word is taken
module telnet_receive_negotiator_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  trn_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output trn_pkg::out_t out_data
);
  import trn_pkg::*;

  trn_parser u_parser (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

>>> src/trn_ring.sv
module trn_ring (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic [7:0] push_data,
  input  logic pop,
  output logic [7:0] pop_data,
  output logic [trn_pkg::RING_AW:0] count
);
  import trn_pkg::*;

  logic [7:0] mem [RING_DEPTH];
  logic [RING_AW-1:0] wptr_r, rptr_r;
  logic [RING_AW:0] count_r;

  // pop and push never occur together: one action per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push && count_r < (RING_AW+1)'(RING_DEPTH)) begin
        wptr_r <= wptr_r + 1'b1;
        count_r <= count_r + 1'b1;
      end else if (pop && count_r != '0) begin
        rptr_r <= rptr_r + 1'b1;
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && count_r < (RING_AW+1)'(RING_DEPTH)) mem[wptr_r] <= push_data;
  end

  // popped byte held until the next pop
  always_ff @(posedge clk) begin
    if (pop) pop_data <= mem[rptr_r];
  end

  assign count = count_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (RING_AW+1)'(RING_DEPTH)) else $error("ring overfull");
  assert property (@(posedge clk) disable iff (!rst_n)
    (pop && count_r == '0) |=> $stable(rptr_r)) else $error("pop on empty moved");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_data != 8'd0 && count_r < (RING_AW+1)'(RING_DEPTH)) |=>
    count_r == $past(count_r) + 1'b1) else $error("push lost");
endmodule

>>> src/trn_parser.sv
module trn_parser (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  trn_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output trn_pkg::out_t out_data
);
  import trn_pkg::*;

  // capture and name stores, synchronous read
  logic [7:0] cap_mem [CAPTURE_DEPTH];
  logic [7:0] name_mem [CAPTURE_DEPTH];
  logic [7:0] cap_rd, name_rd;
  logic [CAP_AW-1:0] cap_raddr;

  pstate_t ps_r, ps_nxt;
  fstate_t fs_r, fs_nxt;
  logic echo_r, echo_nxt, tt_r, tt_nxt;
  logic [7:0] subopt_r, subopt_nxt;
  logic [CAP_AW-1:0] ccnt_r, ccnt_nxt;
  logic [CAP_AW-1:0] nlen_r, nlen_nxt;
  logic [15:0] cols_r, cols_nxt, rows_r, rows_nxt;
  logic [CAP_AW-1:0] fidx_r, fidx_nxt;

  // naws bytes shadowed in flops so SE needs no memory read
  logic [7:0] nb_r [4];

  // reply sequence buffer
  logic [7:0] seq_r [9];
  logic [7:0] seq_nxt [9];
  logic [3:0] slen_r, slen_nxt, spos_r, spos_nxt;
  logic name_pend_r, name_pend_nxt, name_ok_r, name_ok_nxt;
  logic pop_pend_r, pop_pend_nxt, pop_ok_r, pop_ok_nxt;

  logic ovalid_r, ovalid_nxt;
  out_t obuf_r, obuf_nxt;

  logic ring_push, ring_pop;
  logic [7:0] ring_rd;
  logic [RING_AW:0] ring_cnt;
  logic cap_we, name_we;
  logic [CAP_AW-1:0] cap_waddr;
  logic [7:0] cap_wdata;

  logic acc, busy;
  logic [7:0] c;
  logic [7:0] verb;

  trn_ring u_ring (
    .clk(clk), .rst_n(rst_n), .push(ring_push), .push_data(c),
    .pop(ring_pop), .pop_data(ring_rd), .count(ring_cnt)
  );

  assign busy = (fs_r != FS_RUN) || (slen_r != '0) || name_pend_r || pop_pend_r;
  assign in_ready = !busy && (!ovalid_r || out_ready);
  assign acc = in_valid && in_ready;
  assign c = in_data.byte_in;
  assign out_valid = ovalid_r;
  assign out_data = obuf_r;

  always_comb begin
    fs_nxt = fs_r;
    unique case (fs_r)
      FS_RUN: if (acc && in_data.action == ACT_RX && ps_r == PS_VALIAC && c == B_SE
                  && subopt_r == OPT_TTYPE) fs_nxt = FS_NAME;
      FS_NAME: if (cap_rd == 8'd0 || fidx_r == ccnt_r) fs_nxt = FS_EMIT;
      FS_EMIT: if (!ovalid_r || out_ready) fs_nxt = FS_RUN;
      default: fs_nxt = FS_RUN;
    endcase
  end

  always_comb begin
    ps_nxt = ps_r; echo_nxt = echo_r; tt_nxt = tt_r; subopt_nxt = subopt_r;
    ccnt_nxt = ccnt_r; nlen_nxt = nlen_r; cols_nxt = cols_r; rows_nxt = rows_r;
    fidx_nxt = fidx_r;
    seq_nxt = seq_r; slen_nxt = slen_r; spos_nxt = spos_r;
    name_pend_nxt = 1'b0; name_ok_nxt = name_ok_r;
    pop_pend_nxt = 1'b0; pop_ok_nxt = pop_ok_r;
    ovalid_nxt = ovalid_r; obuf_nxt = obuf_r;
    ring_push = 1'b0; ring_pop = 1'b0;
    cap_we = 1'b0; cap_waddr = ccnt_r; cap_wdata = c; name_we = 1'b0;
    cap_raddr = fidx_r;
    verb = B_WONT;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;

    if (acc) begin
      spos_nxt = '0; slen_nxt = '0;
      unique case (action_t'(in_data.action))
        ACT_RX: begin
          unique case (ps_r)
            PS_CMD: begin
              ps_nxt = PS_DATA;
              if (c == B_IAC) ring_push = 1'b1;
              else if (c == B_WILL) ps_nxt = PS_WILL;
              else if (c == B_WONT) ps_nxt = PS_WONT;
              else if (c == B_DO) ps_nxt = PS_DO;
              else if (c == B_DONT) ps_nxt = PS_DONT;
              else if (c == B_SB) ps_nxt = PS_SB;
            end
            PS_DO: begin
              ps_nxt = PS_DATA;
              if (c == OPT_ECHO) echo_nxt = 1'b1;
              else begin
                verb = (c == OPT_TTYPE || c == OPT_SGA) ? B_WILL : B_WONT;
                seq_nxt[0] = B_IAC; seq_nxt[1] = verb; seq_nxt[2] = c; slen_nxt = 4'd3;
              end
            end
            PS_WILL: begin
              ps_nxt = PS_DATA;
              verb = B_DONT;
              if (c == OPT_ECHO || c == OPT_NAWS) verb = B_DO;
              else if (c == OPT_TTYPE && !tt_r) begin
                verb = B_DO; tt_nxt = 1'b1;
              end
              seq_nxt[0] = B_IAC; seq_nxt[1] = verb; seq_nxt[2] = c; slen_nxt = 4'd3;
              if (c == OPT_TTYPE) begin
                seq_nxt[3] = B_IAC; seq_nxt[4] = B_SB; seq_nxt[5] = OPT_TTYPE;
                seq_nxt[6] = SUB_SEND; seq_nxt[7] = B_IAC; seq_nxt[8] = B_SE;
                slen_nxt = 4'd9;
              end
            end
            PS_DONT: begin
              ps_nxt = PS_DATA;
              if (c == OPT_ECHO) echo_nxt = 1'b0;
            end
            PS_WONT: begin
              ps_nxt = PS_DATA;
              if (c != OPT_ECHO) begin
                seq_nxt[0] = B_IAC; seq_nxt[1] = B_DONT; seq_nxt[2] = c; slen_nxt = 4'd3;
              end
            end
            PS_SB: begin
              subopt_nxt = c;
              if (c == OPT_TTYPE) ps_nxt = PS_SBOPT;
              else begin
                ccnt_nxt = '0; ps_nxt = PS_VAL;
              end
            end
            PS_SBOPT: begin
              if (c == SUB_IS) begin
                ccnt_nxt = '0; ps_nxt = PS_VAL;
              end else ps_nxt = PS_DATA;
            end
            PS_VAL, PS_VALIAC: begin
              if (ps_r == PS_VAL && c == B_IAC) ps_nxt = PS_VALIAC;
              else if (ps_r == PS_VAL || c == B_IAC) begin
                ps_nxt = PS_VAL;
                if (ccnt_r != '1) begin
                  cap_we = 1'b1; ccnt_nxt = ccnt_r + 1'b1;
                end
              end else begin
                ps_nxt = PS_DATA;
                if (c == B_SE) begin
                  if (subopt_r == OPT_TTYPE) begin
                    fidx_nxt = '0; cap_raddr = '0;
                  end else if (subopt_r == OPT_NAWS) begin
                    cols_nxt = {nb_r[0], nb_r[1]};
                    rows_nxt = {nb_r[2], nb_r[3]};
                  end
                end
              end
            end
            default: begin
              if (c == B_IAC) ps_nxt = PS_CMD;
              else begin
                ps_nxt = PS_DATA; ring_push = (c != 8'd0);
              end
            end
          endcase
          if (fs_nxt == FS_RUN) begin
            obuf_nxt = '0;
            obuf_nxt.kind = (slen_nxt != '0) ? K_REPLY : K_NONE;
            obuf_nxt.value = (slen_nxt != '0) ? B_IAC : 8'd0;
            obuf_nxt.last = (slen_nxt == '0);
            if (slen_nxt != '0) begin
              spos_nxt = 4'd1;
              if (slen_nxt == 4'd1) slen_nxt = '0;
            end
            ovalid_nxt = 1'b1;
          end
        end
        ACT_POP: begin
          pop_pend_nxt = 1'b1; pop_ok_nxt = (ring_cnt != '0); ring_pop = 1'b1;
        end
        ACT_NAME: begin
          name_pend_nxt = 1'b1;
          name_ok_nxt = (in_data.name_index < nlen_r);
        end
        default: begin
          obuf_nxt = '0; obuf_nxt.kind = K_NONE; obuf_nxt.last = 1'b1;
          ovalid_nxt = 1'b1;
        end
      endcase
    end else if (fs_r == FS_NAME) begin
      // copy one captured byte a cycle; cap_rd holds entry fidx_r
      cap_raddr = fidx_r + 1'b1;
      fidx_nxt = fidx_r + 1'b1;
    end else if (fs_r == FS_EMIT) begin
      if (!ovalid_r || out_ready) begin
        obuf_nxt = '0; obuf_nxt.kind = K_NONE; obuf_nxt.last = 1'b1;
        ovalid_nxt = 1'b1;
      end
    end else if (pop_pend_r || name_pend_r) begin
      if (!ovalid_r || out_ready) begin
        obuf_nxt = '0;
        obuf_nxt.last = 1'b1;
        if (pop_pend_r) begin
          obuf_nxt.kind = pop_ok_r ? K_DATA : K_EMPTY;
          obuf_nxt.value = pop_ok_r ? ring_rd : 8'd0;
        end else begin
          obuf_nxt.kind = K_NAME;
          obuf_nxt.value = name_ok_r ? name_rd : 8'd0;
        end
        ovalid_nxt = 1'b1;
      end else begin
        pop_pend_nxt = pop_pend_r; name_pend_nxt = name_pend_r;
      end
    end else if (slen_r != '0) begin
      if (!ovalid_r || out_ready) begin
        obuf_nxt = '0; obuf_nxt.kind = K_REPLY;
        obuf_nxt.value = seq_r[spos_r];
        obuf_nxt.last = (spos_r + 1'b1 == slen_r);
        ovalid_nxt = 1'b1;
        spos_nxt = spos_r + 1'b1;
        if (spos_r + 1'b1 == slen_r) slen_nxt = '0;
      end
    end

    // name copy: check byte read last cycle
    if (fs_r == FS_NAME) begin
      if (fidx_r == ccnt_r || cap_rd == 8'd0) begin
        nlen_nxt = fidx_r;
      end else begin
        name_we = 1'b1;
        nlen_nxt = fidx_r + 1'b1;
      end
    end

    obuf_nxt.echo_on = echo_nxt;
    obuf_nxt.window_cols = cols_nxt;
    obuf_nxt.window_rows = rows_nxt;
    obuf_nxt.data_count = (ring_push && ring_cnt < (RING_AW+1)'(RING_DEPTH)) ?
                          ring_cnt + 1'b1 : ring_cnt;
    obuf_nxt.name_length = nlen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) nb_r[i] <= 8'd0;
    end else if (acc && in_data.action == ACT_RX) begin
      if ((ps_r == PS_SB && c != OPT_TTYPE) || (ps_r == PS_SBOPT && c == SUB_IS)) begin
        for (int i = 0; i < 4; i++) nb_r[i] <= 8'd0;
      end else if (cap_we && ccnt_r < CAP_AW'(4)) begin
        nb_r[ccnt_r[1:0]] <= c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_waddr] <= cap_wdata;
    cap_rd <= cap_mem[cap_raddr];
  end

  always_ff @(posedge clk) begin
    if (name_we) name_mem[fidx_r] <= cap_rd;
    if (acc && in_data.action == ACT_NAME) name_rd <= name_mem[in_data.name_index];
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    obuf_r <= obuf_nxt;
    fidx_r <= fidx_nxt;
    name_ok_r <= name_ok_nxt;
    pop_ok_r <= pop_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= PS_DATA; fs_r <= FS_RUN;
      echo_r <= 1'b0; tt_r <= 1'b0; subopt_r <= '0; ccnt_r <= '0; nlen_r <= '0;
      cols_r <= '0; rows_r <= '0; slen_r <= '0; spos_r <= '0;
      name_pend_r <= 1'b0; pop_pend_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      ps_r <= ps_nxt; fs_r <= fs_nxt;
      echo_r <= echo_nxt; tt_r <= tt_nxt; subopt_r <= subopt_nxt;
      ccnt_r <= ccnt_nxt; nlen_r <= nlen_nxt; cols_r <= cols_nxt; rows_r <= rows_nxt;
      slen_r <= slen_nxt; spos_r <= spos_nxt;
      name_pend_r <= name_pend_nxt; pop_pend_r <= pop_pend_nxt; ovalid_r <= ovalid_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready) else $error("accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (fs_r == FS_NAME) |-> !ovalid_r) else $error("word pending during name copy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (slen_r != '0) |-> spos_r < slen_r) else $error("reply index overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ready) |=> ovalid_r && $stable(obuf_r)) else $error("result lost");
endmodule

>>> bench/telnet_negotiation_checker.sv
module telnet_negotiation_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  trn_pkg::in_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  trn_pkg::out_t out_data,
  output int fail_count,
  output int pending_words,
  output int words_seen
);
  import trn_pkg::*;

  out_t expected_words[$];

  pstate_t ps;
  logic echo_flag, ttype_asked;
  logic [7:0] sub_opt;
  int cap_count, name_len, ring_count, rd_ptr, wr_ptr;
  logic [7:0] cap_mem[CAPTURE_DEPTH];
  logic [7:0] name_mem[CAPTURE_DEPTH];
  logic [7:0] ring_mem[RING_DEPTH];
  logic [15:0] cols, rows;
  logic [2:0] pend_kind[$];
  logic [7:0] pend_val[$];

  assign pending_words = expected_words.size();

  function automatic void add_word(logic [2:0] k, logic [7:0] v);
    pend_kind.push_back(k);
    pend_val.push_back(v);
  endfunction

  function automatic void add_triplet(logic [7:0] verb, logic [7:0] opt);
    add_word(K_REPLY, B_IAC);
    add_word(K_REPLY, verb);
    add_word(K_REPLY, opt);
  endfunction

  function automatic void ring_push(logic [7:0] c);
    if (c == 8'd0 || ring_count >= RING_DEPTH) return;
    ring_mem[wr_ptr] = c;
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    ring_count++;
  endfunction

  function automatic void capture_byte(logic [7:0] c);
    if (cap_count < CAPTURE_DEPTH - 1) begin
      cap_mem[cap_count] = c;
      cap_count++;
    end
  endfunction

  function automatic logic [7:0] cap_byte(int i);
    return (i < cap_count) ? cap_mem[i] : 8'd0;
  endfunction

  function automatic void close_subneg();
    int n;
    n = 0;
    if (sub_opt == OPT_TTYPE) begin
      while (n < cap_count && cap_mem[n] != 8'd0) begin
        name_mem[n] = cap_mem[n];
        n++;
      end
      name_len = n;
    end else if (sub_opt == OPT_NAWS) begin
      cols = {cap_byte(0), cap_byte(1)};
      rows = {cap_byte(2), cap_byte(3)};
    end
  endfunction

  function automatic void parse_rx(logic [7:0] c);
    logic [7:0] verb;
    case (ps)
      PS_CMD: begin
        ps = PS_DATA;
        if (c == B_IAC) ring_push(c);
        else if (c == B_WILL) ps = PS_WILL;
        else if (c == B_WONT) ps = PS_WONT;
        else if (c == B_DO) ps = PS_DO;
        else if (c == B_DONT) ps = PS_DONT;
        else if (c == B_SB) ps = PS_SB;
      end
      PS_DO: begin
        ps = PS_DATA;
        if (c == OPT_ECHO) echo_flag = 1'b1;
        else add_triplet((c == OPT_TTYPE || c == OPT_SGA) ? B_WILL : B_WONT, c);
      end
      PS_WILL: begin
        ps = PS_DATA;
        verb = B_DONT;
        if (c == OPT_ECHO || c == OPT_NAWS) verb = B_DO;
        else if (c == OPT_TTYPE && !ttype_asked) begin
          verb = B_DO;
          ttype_asked = 1'b1;
        end
        add_triplet(verb, c);
        if (c == OPT_TTYPE) begin
          add_word(K_REPLY, B_IAC);
          add_word(K_REPLY, B_SB);
          add_word(K_REPLY, OPT_TTYPE);
          add_word(K_REPLY, SUB_SEND);
          add_word(K_REPLY, B_IAC);
          add_word(K_REPLY, B_SE);
        end
      end
      PS_DONT: begin
        ps = PS_DATA;
        if (c == OPT_ECHO) echo_flag = 1'b0;
      end
      PS_WONT: begin
        ps = PS_DATA;
        if (c != OPT_ECHO) add_triplet(B_DONT, c);
      end
      PS_SB: begin
        sub_opt = c;
        if (c == OPT_TTYPE) ps = PS_SBOPT;
        else begin
          cap_count = 0;
          ps = PS_VAL;
        end
      end
      PS_SBOPT: begin
        if (c == SUB_IS) begin
          cap_count = 0;
          ps = PS_VAL;
        end else ps = PS_DATA;
      end
      PS_VAL: begin
        if (c == B_IAC) ps = PS_VALIAC;
        else capture_byte(c);
      end
      PS_VALIAC: begin
        if (c == B_IAC) begin
          capture_byte(c);
          ps = PS_VAL;
        end else begin
          if (c == B_SE) close_subneg();
          ps = PS_DATA;
        end
      end
      default: begin
        if (c == B_IAC) ps = PS_CMD;
        else ring_push(c);
      end
    endcase
  endfunction

  task automatic predict_word(in_t w);
    out_t o;
    pend_kind.delete();
    pend_val.delete();
    case (action_t'(w.action))
      ACT_RX: begin
        parse_rx(w.byte_in);
        if (pend_kind.size() == 0) add_word(K_NONE, 8'd0);
      end
      ACT_POP: begin
        if (ring_count == 0) add_word(K_EMPTY, 8'd0);
        else begin
          add_word(K_DATA, ring_mem[rd_ptr]);
          rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          ring_count--;
        end
      end
      ACT_NAME: add_word(K_NAME, (w.name_index < name_len) ? name_mem[w.name_index] : 8'd0);
      default: add_word(K_NONE, 8'd0);
    endcase
    foreach (pend_kind[i]) begin
      o.kind = pend_kind[i];
      o.value = pend_val[i];
      o.last = (i == pend_kind.size() - 1);
      o.echo_on = echo_flag;
      o.window_cols = cols;
      o.window_rows = rows;
      o.data_count = ring_count[8:0];
      o.name_length = name_len[5:0];
      expected_words.push_back(o);
    end
  endtask

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      ps = PS_DATA;
      echo_flag = 1'b0;
      ttype_asked = 1'b0;
      sub_opt = '0;
      cap_count = 0;
      name_len = 0;
      ring_count = 0;
      rd_ptr = 0;
      wr_ptr = 0;
      cols = '0;
      rows = '0;
      expected_words.delete();
    end else begin
      // compare before predicting so a same-edge input cannot jump the queue
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_words.size() == 0) report("unexpected word", 0, 32'(out_data.kind));
        else begin
          e = expected_words.pop_front();
          if (out_data.kind !== e.kind) report("kind", 32'(e.kind), 32'(out_data.kind));
          if (out_data.value !== e.value) report("value", 32'(e.value), 32'(out_data.value));
          if (out_data.last !== e.last) report("last", 32'(e.last), 32'(out_data.last));
          if (out_data.echo_on !== e.echo_on)
            report("echo_on", 32'(e.echo_on), 32'(out_data.echo_on));
          if (out_data.window_cols !== e.window_cols)
            report("window_cols", 32'(e.window_cols), 32'(out_data.window_cols));
          if (out_data.window_rows !== e.window_rows)
            report("window_rows", 32'(e.window_rows), 32'(out_data.window_rows));
          if (out_data.data_count !== e.data_count)
            report("data_count", 32'(e.data_count), 32'(out_data.data_count));
          if (out_data.name_length !== e.name_length)
            report("name_length", 32'(e.name_length), 32'(out_data.name_length));
        end
      end
      if (in_valid && in_ready) predict_word(in_data);
    end
  end

  initial begin
    fail_count = 0;
    words_seen = 0;
  end
endmodule

>>> bench/tb_telnet_receive_negotiator_unit.sv
module tb_telnet_receive_negotiator_unit;
  import trn_pkg::*;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  int fail_count, pending_words, words_seen, sent;
  bit calm;

  telnet_receive_negotiator_unit dut (.*);

  telnet_negotiation_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .fail_count(fail_count), .pending_words(pending_words),
    .words_seen(words_seen)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  // receiver stalls about 7 in 100 outside the calm stretch
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 7);
  end

  // valid stays up between back-to-back words; idle cycles drop it
  task automatic send(logic [1:0] act, logic [7:0] b, logic [5:0] idx);
    if (!calm) while ($urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= '{action: act, byte_in: b, name_index: idx};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic rx(logic [7:0] b);
    send(ACT_RX, b, 6'($urandom_range(63)));
  endtask

  task automatic rx_noise();
    send(ACT_RX, 8'($urandom_range(255)), 6'($urandom_range(63)));
  endtask

  task automatic random_sequence();
    int n;
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1: repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(255));
        rx(b);
        if (b == B_IAC) rx(B_IAC);
      end
      2: begin
        rx(B_IAC);
        rx(8'(B_SE + $urandom_range(15)));
        case ($urandom_range(3))
          0: rx(OPT_ECHO);
          1: rx(OPT_SGA);
          2: rx(OPT_TTYPE);
          default: rx(OPT_NAWS);
        endcase
      end
      3: begin
        rx(B_IAC);
        rx(B_SB);
        rx(OPT_TTYPE);
        rx(($urandom_range(4) == 0) ? SUB_SEND : SUB_IS);
        n = $urandom_range(1, 8);
        repeat (n) begin
          b = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255));
          rx(b);
          if (b == B_IAC) rx(B_IAC);
        end
        rx(B_IAC);
        rx(($urandom_range(5) == 0) ? 8'($urandom_range(255)) : B_SE);
      end
      4: begin
        rx(B_IAC);
        rx(B_SB);
        rx(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : OPT_NAWS);
        repeat ($urandom_range(0, 5)) rx(8'($urandom_range(254)));
        rx(B_IAC);
        rx(B_SE);
      end
      5, 6: send(ACT_POP, 8'($urandom_range(255)), 6'($urandom_range(63)));
      7: send(ACT_NAME, 8'($urandom_range(255)), 6'($urandom_range(63)));
      8: send(ACT_NONE, 8'($urandom_range(255)), 6'($urandom_range(63)));
      default: rx_noise();
    endcase
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    calm = 0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: empty pop, empty name, unused action, negotiation, subnegotiations
    send(ACT_POP, 8'hFF, 6'h3F);
    send(ACT_NAME, 8'h00, 6'h00);
    send(ACT_NONE, 8'hFF, 6'h3F);
    rx(8'h00); rx(8'h41); rx(B_IAC); rx(B_IAC);
    rx(B_IAC); rx(B_DO); rx(OPT_ECHO);
    rx(B_IAC); rx(B_WILL); rx(OPT_TTYPE);
    rx(B_IAC); rx(B_WILL); rx(OPT_TTYPE);
    rx(B_IAC); rx(B_WONT); rx(8'h05);
    rx(B_IAC); rx(B_DONT); rx(OPT_ECHO);
    rx(B_IAC); rx(B_SB); rx(OPT_NAWS); rx(8'hFF); rx(8'hFF); rx(8'h00);
    rx(B_IAC); rx(B_SE);
    rx(B_IAC); rx(B_SB); rx(OPT_TTYPE); rx(SUB_IS);
    rx(8'h76); rx(8'h74); rx(8'h00); rx(8'h58); rx(B_IAC); rx(B_SE);
    send(ACT_NAME, 8'd0, 6'd1);
    send(ACT_NAME, 8'd0, 6'd63);
    send(ACT_POP, 8'd0, 6'd0);
    send(ACT_POP, 8'd0, 6'd0);

    // fill the capture past its depth, then push a run of data bytes
    calm = 1;
    rx(B_IAC); rx(B_SB); rx(OPT_TTYPE); rx(SUB_IS);
    repeat (66) rx(8'($urandom_range(1, 254)));
    rx(B_IAC); rx(B_SE);
    send(ACT_NAME, 8'd0, 6'd62);
    repeat (40) rx(8'($urandom_range(1, 254)));
    calm = 0;
    repeat (20) send(ACT_POP, 8'd0, 6'd0);

    // hold off until the block has drained
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    repeat (15) random_sequence();
    repeat (10) send(ACT_POP, 8'd0, 6'd0);

    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("sent %0d input words, checked %0d output words", sent, words_seen);
    $display("covered negotiation replies, subnegotiation capture, ring push and pop");
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> telnet_receive_negotiator_unit.f
src/trn_pkg.sv
src/trn_ring.sv
src/trn_parser.sv
src/telnet_receive_negotiator_unit.sv
bench/telnet_negotiation_checker.sv
bench/tb_telnet_receive_negotiator_unit.sv
